[design/mpd_pkg.sv]
// Shared types and constants for the multipart body deframer.
`default_nettype none

package mpd_pkg;

   localparam int BYTE_W     = 8;
   localparam int KIND_W     = 2;
   localparam int IDX_W      = 10;
   localparam int MAXP_W     = 11;
   localparam int RSP_DATA_W = 24;

   localparam logic [BYTE_W-1:0] CHAR_CR         = 8'h0d;
   localparam logic [BYTE_W-1:0] CHAR_LF         = 8'h0a;
   localparam logic [MAXP_W-1:0] MAX_PARTS_RESET = 11'd1024;
   localparam logic [IDX_W-1:0]  IDX_SAT         = 10'd1023;

   typedef enum logic [KIND_W-1:0] {
      KIND_HEAD,
      KIND_BODY,
      KIND_PEND,
      KIND_MEND
   } kind_type;

   typedef enum logic [1:0] {
      SRC_ZERO,
      SRC_BYTE,
      SRC_CR,
      SRC_DELIM
   } src_type;

   typedef enum logic [1:0] {
      PTR_FOLLOW,
      PTR_ONE,
      PTR_NEXT,
      PTR_HOLD
   } ptr_op_type;

   typedef struct packed {
      logic       accept;
      logic       emit;
      src_type    src;
      kind_type   kind;
      logic       last;
      logic       delim_write;
      logic       hdr_init;
      logic       hdr_step;
      logic       body_hit;
      logic       match_load;
      ptr_op_type ptr_op;
      logic       part_inc;
      logic       clear;
   } cmd_type;

   typedef struct packed {
      logic emit_ok;
      logic byte_cr;
      logic byte_lf;
      logic store_full;
      logic limit_hit;
      logic hdr_emit_cr;
      logic hdr_emit_byte;
      logic hdr_to_body;
      logic body_match;
      logic body_done;
      logic match_zero;
      logic match_one;
      logic replay_last;
   } stat_type;

endpackage

`default_nettype wire

[design/mpd_datapath.sv]
// Datapath: delimiter store, match and part counters, header tracking, result register.
`default_nettype none

module mpd_datapath #(
   parameter int DELIM_MAX  = 64,
   parameter int PART_LIMIT = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [mpd_pkg::BYTE_W-1:0]     req_byte,
   input  logic                           csr_valid,
   input  logic [mpd_pkg::MAXP_W-1:0]     csr_data,
   input  mpd_pkg::cmd_type               cmd,
   output mpd_pkg::stat_type              stat,
   input  logic                           rsp_tready,
   output logic                           rsp_tvalid,
   output logic [mpd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [mpd_pkg::KIND_W-1:0]     rsp_tuser,
   output logic                           rsp_tlast
);
   import mpd_pkg::*;

   localparam int AW   = $clog2(DELIM_MAX);
   localparam int LENW = $clog2(DELIM_MAX + 1);
   localparam int PCW  = $clog2(PART_LIMIT + 1);
   localparam int CW   = (PCW > MAXP_W) ? PCW : MAXP_W;
   localparam int PADW = RSP_DATA_W - BYTE_W - IDX_W;

   logic [BYTE_W-1:0] delim_mem [DELIM_MAX];
   logic [BYTE_W-1:0] rd_data_ff;

   logic [AW-1:0]     ptr_ff, ptr_in;
   logic [AW-1:0]     match_count_ff, match_count_in;
   logic [LENW-1:0]   delim_len_ff, delim_len_in;
   logic [PCW-1:0]    part_count_ff, part_count_in;
   logic              line_empty_ff, line_empty_in;
   logic              cr_seen_ff, cr_seen_in;
   logic [MAXP_W-1:0] max_parts_ff, max_parts_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff;
   logic [KIND_W-1:0] rsp_kind_ff;
   logic [IDX_W-1:0]  rsp_idx_ff;
   logic              rsp_last_ff;

   logic [BYTE_W-1:0] cur_byte;
   logic [BYTE_W-1:0] delim_byte;
   logic [BYTE_W-1:0] emit_byte;
   logic [CW-1:0]     limit_val;
   logic [CW-1:0]     part_wide;
   logic [IDX_W-1:0]  idx_sat;
   logic [LENW-1:0]   match_inc;
   logic              cur_cr, cur_lf;
   logic              hdr_emit_cr, hdr_emit_byte, hdr_le;

   assign cur_byte = cmd.accept ? req_byte : byte_ff;
   assign cur_cr   = (cur_byte == CHAR_CR);
   assign cur_lf   = (cur_byte == CHAR_LF);

   assign delim_byte = (ptr_ff == AW'(0)) ? CHAR_CR :
                       (ptr_ff == AW'(1)) ? CHAR_LF : rd_data_ff;

   assign limit_val = (CW'(max_parts_ff) < CW'(PART_LIMIT)) ? CW'(max_parts_ff)
                                                             : CW'(PART_LIMIT);
   assign part_wide = CW'(part_count_ff);
   assign idx_sat   = (part_wide > CW'(IDX_SAT)) ? IDX_SAT : part_wide[IDX_W-1:0];
   assign match_inc = LENW'(match_count_ff) + LENW'(1);

   assign hdr_emit_cr   = cr_seen_ff && !(cur_lf && line_empty_ff);
   assign hdr_le        = line_empty_ff && !hdr_emit_cr;
   assign hdr_emit_byte = !cur_cr && !(cur_lf && hdr_le);

   always_comb begin
      stat               = '0;
      stat.emit_ok       = !rsp_valid_ff || rsp_tready;
      stat.byte_cr       = cur_cr;
      stat.byte_lf       = cur_lf;
      stat.store_full    = (delim_len_ff >= LENW'(DELIM_MAX));
      stat.limit_hit     = (part_wide >= limit_val);
      stat.hdr_emit_cr   = hdr_emit_cr;
      stat.hdr_emit_byte = hdr_emit_byte;
      stat.hdr_to_body   = cur_lf && hdr_le;
      stat.body_match    = (cur_byte == delim_byte);
      stat.body_done     = (match_inc >= delim_len_ff);
      stat.match_zero    = (match_count_ff == AW'(0));
      stat.match_one     = (match_count_ff == AW'(1));
      stat.replay_last   = ((LENW'(ptr_ff) + LENW'(1)) == LENW'(match_count_ff));
   end

   always_comb begin
      match_count_in = match_count_ff;
      if (cmd.clear) begin
         match_count_in = '0;
      end else if (cmd.body_hit) begin
         match_count_in = stat.body_done ? AW'(0) : AW'(match_inc);
      end else if (cmd.match_load) begin
         match_count_in = cur_cr ? AW'(1) : AW'(0);
      end

      case (cmd.ptr_op)
         PTR_FOLLOW: ptr_in = match_count_in;
         PTR_ONE:    ptr_in = AW'(1);
         PTR_NEXT:   ptr_in = ptr_ff + AW'(1);
         PTR_HOLD:   ptr_in = ptr_ff;
         default:    ptr_in = match_count_in;
      endcase

      delim_len_in = delim_len_ff;
      if (cmd.clear) begin
         delim_len_in = LENW'(2);
      end else if (cmd.delim_write) begin
         delim_len_in = delim_len_ff + LENW'(1);
      end

      part_count_in = part_count_ff;
      if (cmd.clear) begin
         part_count_in = '0;
      end else if (cmd.part_inc) begin
         part_count_in = part_count_ff + PCW'(1);
      end

      line_empty_in = line_empty_ff;
      cr_seen_in    = cr_seen_ff;
      if (cmd.clear || cmd.hdr_init) begin
         line_empty_in = 1'b1;
         cr_seen_in    = 1'b0;
      end else if (cmd.hdr_step) begin
         line_empty_in = hdr_emit_byte ? cur_lf : hdr_le;
         cr_seen_in    = cur_cr;
      end

      max_parts_in = csr_valid ? csr_data : max_parts_ff;
      byte_in      = cur_byte;
      rsp_valid_in = cmd.emit || (rsp_valid_ff && !rsp_tready);

      case (cmd.src)
         SRC_ZERO:  emit_byte = '0;
         SRC_BYTE:  emit_byte = cur_byte;
         SRC_CR:    emit_byte = CHAR_CR;
         SRC_DELIM: emit_byte = delim_byte;
         default:   emit_byte = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.delim_write) begin
         delim_mem[delim_len_ff[AW-1:0]] <= cur_byte;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= delim_mem[ptr_in];
      byte_ff    <= byte_in;
      if (cmd.emit) begin
         rsp_byte_ff <= emit_byte;
         rsp_kind_ff <= cmd.kind;
         rsp_idx_ff  <= idx_sat;
         rsp_last_ff <= cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff         <= '0;
         match_count_ff <= '0;
         delim_len_ff   <= LENW'(2);
         part_count_ff  <= '0;
         line_empty_ff  <= 1'b1;
         cr_seen_ff     <= 1'b0;
         max_parts_ff   <= MAX_PARTS_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         ptr_ff         <= ptr_in;
         match_count_ff <= match_count_in;
         delim_len_ff   <= delim_len_in;
         part_count_ff  <= part_count_in;
         line_empty_ff  <= line_empty_in;
         cr_seen_ff     <= cr_seen_in;
         max_parts_ff   <= max_parts_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PADW{1'b0}}, rsp_idx_ff, rsp_byte_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_emit_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwrites an untaken transfer");

   a_match_below_len: assert property (@(posedge clock) disable iff (reset)
      LENW'(match_count_ff) < delim_len_ff)
      else $error("match count reached delimiter length");

   a_part_bounded: assert property (@(posedge clock) disable iff (reset)
      CW'(part_count_ff) <= CW'(PART_LIMIT))
      else $error("part count beyond limit");

endmodule

`default_nettype wire

[design/mpd_ctrl.sv]
// Controller: message phase and per-item result sequencing.
`default_nettype none

module mpd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tuser,
   output logic              req_tready,
   input  mpd_pkg::stat_type stat,
   output mpd_pkg::cmd_type  cmd
);
   import mpd_pkg::*;

   typedef enum logic [3:0] {
      ST_DELIM,
      ST_DELIM_LF,
      ST_HEADER,
      ST_BODY,
      ST_TRAIL_CR,
      ST_TRAIL_LF,
      ST_DONE,
      ST_HDR2,
      ST_REPLAY,
      ST_BODYB,
      ST_MEND
   } state_type;

   state_type state_ff, state_in;
   logic      in_phase;
   logic      fire;
   logic      start_part;
   logic      msg_end;

   assign in_phase = (state_ff == ST_DELIM) || (state_ff == ST_DELIM_LF) ||
                     (state_ff == ST_HEADER) || (state_ff == ST_BODY) ||
                     (state_ff == ST_TRAIL_CR) || (state_ff == ST_TRAIL_LF) ||
                     (state_ff == ST_DONE);
   assign req_tready = in_phase && stat.emit_ok;
   assign fire       = req_tvalid && req_tready;

   always_comb begin
      cmd        = '0;
      cmd.src    = SRC_ZERO;
      cmd.kind   = KIND_HEAD;
      cmd.ptr_op = PTR_FOLLOW;
      state_in   = state_ff;
      start_part = 1'b0;
      msg_end    = 1'b0;

      case (state_ff)
         ST_HDR2: begin
            if (stat.emit_ok) begin
               cmd.emit = 1'b1;
               cmd.src  = SRC_BYTE;
               cmd.kind = KIND_HEAD;
               cmd.last = 1'b1;
               state_in = ST_HEADER;
            end
         end
         ST_BODYB: begin
            if (stat.emit_ok) begin
               cmd.emit = 1'b1;
               cmd.src  = SRC_BYTE;
               cmd.kind = KIND_BODY;
               cmd.last = 1'b1;
               state_in = ST_BODY;
            end
         end
         ST_REPLAY: begin
            if (stat.emit_ok) begin
               cmd.emit = 1'b1;
               cmd.src  = SRC_DELIM;
               cmd.kind = KIND_BODY;
               cmd.last = stat.replay_last && stat.byte_cr;
               if (stat.replay_last) begin
                  cmd.match_load = 1'b1;
                  state_in       = stat.byte_cr ? ST_BODY : ST_BODYB;
               end else begin
                  cmd.ptr_op = PTR_NEXT;
               end
            end else begin
               cmd.ptr_op = PTR_HOLD;
            end
         end
         ST_MEND: begin
            if (stat.emit_ok) begin
               cmd.emit  = 1'b1;
               cmd.kind  = KIND_MEND;
               cmd.last  = 1'b1;
               cmd.clear = 1'b1;
               state_in  = ST_DELIM;
            end
         end
         ST_DELIM, ST_DELIM_LF, ST_HEADER, ST_BODY, ST_TRAIL_CR, ST_TRAIL_LF,
         ST_DONE: begin
            if (fire) begin
               cmd.accept = 1'b1;
               if (req_tuser) begin
                  case (state_ff)
                     ST_DONE: begin
                        cmd.clear = 1'b1;
                        state_in  = ST_DELIM;
                     end
                     ST_TRAIL_CR, ST_TRAIL_LF: begin
                        cmd.emit  = 1'b1;
                        cmd.kind  = KIND_MEND;
                        cmd.last  = 1'b1;
                        cmd.clear = 1'b1;
                        state_in  = ST_DELIM;
                     end
                     ST_DELIM, ST_DELIM_LF: begin
                        cmd.emit = 1'b1;
                        if (stat.limit_hit) begin
                           cmd.kind  = KIND_MEND;
                           cmd.last  = 1'b1;
                           cmd.clear = 1'b1;
                           state_in  = ST_DELIM;
                        end else begin
                           cmd.kind     = KIND_PEND;
                           cmd.part_inc = 1'b1;
                           state_in     = ST_MEND;
                        end
                     end
                     default: begin
                        cmd.emit     = 1'b1;
                        cmd.kind     = KIND_PEND;
                        cmd.part_inc = 1'b1;
                        state_in     = ST_MEND;
                     end
                  endcase
               end else begin
                  case (state_ff)
                     ST_DELIM: begin
                        if (stat.byte_cr) begin
                           state_in = ST_DELIM_LF;
                        end else if (stat.store_full) begin
                           start_part = 1'b1;
                        end else begin
                           cmd.delim_write = 1'b1;
                        end
                     end
                     ST_DELIM_LF: begin
                        start_part = 1'b1;
                     end
                     ST_HEADER: begin
                        cmd.hdr_step = 1'b1;
                        cmd.kind     = KIND_HEAD;
                        if (stat.hdr_emit_cr) begin
                           cmd.emit = 1'b1;
                           cmd.src  = SRC_CR;
                           cmd.last = !stat.hdr_emit_byte;
                           if (stat.hdr_emit_byte) begin
                              state_in = ST_HDR2;
                           end
                        end else if (stat.hdr_emit_byte) begin
                           cmd.emit = 1'b1;
                           cmd.src  = SRC_BYTE;
                           cmd.last = 1'b1;
                        end
                        if (stat.hdr_to_body) begin
                           state_in = ST_BODY;
                        end
                     end
                     ST_BODY: begin
                        cmd.kind = KIND_BODY;
                        if (stat.body_match) begin
                           cmd.body_hit = 1'b1;
                           if (stat.body_done) begin
                              cmd.emit     = 1'b1;
                              cmd.kind     = KIND_PEND;
                              cmd.last     = 1'b1;
                              cmd.part_inc = 1'b1;
                              state_in     = ST_TRAIL_CR;
                           end
                        end else if (stat.match_zero) begin
                           cmd.emit = 1'b1;
                           cmd.src  = SRC_BYTE;
                           cmd.last = 1'b1;
                        end else begin
                           cmd.emit = 1'b1;
                           cmd.src  = SRC_CR;
                           if (stat.match_one) begin
                              cmd.match_load = 1'b1;
                              cmd.last       = stat.byte_cr;
                              if (!stat.byte_cr) begin
                                 state_in = ST_BODYB;
                              end
                           end else begin
                              cmd.ptr_op = PTR_ONE;
                              state_in   = ST_REPLAY;
                           end
                        end
                     end
                     ST_TRAIL_CR: begin
                        if (stat.byte_cr) begin
                           state_in = ST_TRAIL_LF;
                        end else begin
                           msg_end = 1'b1;
                        end
                     end
                     ST_TRAIL_LF: begin
                        if (stat.byte_lf) begin
                           start_part = 1'b1;
                        end else begin
                           msg_end = 1'b1;
                        end
                     end
                     default: begin
                        state_in = state_ff;
                     end
                  endcase
               end
            end
         end
         default: begin
            state_in = ST_DELIM;
         end
      endcase

      if (start_part && !stat.limit_hit) begin
         cmd.hdr_init = 1'b1;
         state_in     = ST_HEADER;
      end
      if ((start_part && stat.limit_hit) || msg_end) begin
         cmd.emit = 1'b1;
         cmd.src  = SRC_ZERO;
         cmd.kind = KIND_MEND;
         cmd.last = 1'b1;
         state_in = ST_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_DELIM;
      end else begin
         state_ff <= state_in;
      end
   end

   a_replay_needs_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REPLAY) |-> (!stat.match_zero && !stat.match_one))
      else $error("replay entered with fewer than two matched bytes");

endmodule

`default_nettype wire

[design/multipart_body_deframer_top.sv]
// Top level of the multipart body deframer.
//
// req_* carries one content byte per transfer; req_tuser high marks the end of
// the stream and the byte is ignored. rsp_* returns header bytes, body bytes,
// part-end and message-end markers; rsp_tlast flags the last result of each
// input transfer. csr_* writes max_parts and is always ready.
// A result is registered and shows on rsp_* in the cycle after the transfer causing it.
// One result is produced per cycle while the receiver takes them. A transfer giving more
// than one result holds input off until they are out: a header CR and the byte after it,
// the part end and message end at the end of stream inside a part, and after a body
// mismatch the matched delimiter bytes, then the mismatching byte unless it is a CR. The
// delimiter store feeds one registered read per cycle while results are taken, pacing the replay.
// A single output register parts the channels: input is taken while a result
// waits as long as that result is taken in the same cycle. When the receiver
// stalls, the pending result holds and input stalls with it.
// Reset returns to the delimiter-line phase with max_parts at 1024; the block
// takes input as soon as reset is released, with no clearing pass.
`default_nettype none

module multipart_body_deframer_top #(
   parameter int DELIM_MAX  = 64,
   parameter int PART_LIMIT = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [mpd_pkg::BYTE_W-1:0]     req_tdata,   // [7:0] data_byte
   input  logic                           req_tuser,   // [0] stream_end
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [mpd_pkg::RSP_DATA_W-1:0] rsp_tdata,   // [7:0] out_byte, [17:8] part_index
   output logic [mpd_pkg::KIND_W-1:0]     rsp_tuser,   // [1:0] kind
   output logic                           rsp_tlast,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [mpd_pkg::MAXP_W-1:0]     csr_data
);
   import mpd_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   mpd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   mpd_datapath #(
      .DELIM_MAX  (DELIM_MAX),
      .PART_LIMIT (PART_LIMIT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_byte   (req_tdata),
      .csr_valid  (csr_valid && csr_ready),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for the multipart body deframer: directed and random byte streams.
module tb;
   import mpd_pkg::*;

   localparam int DELIM_MAX       = 64;
   localparam int PART_LIMIT      = 1024;
   localparam int ITEMS_PER_PHASE = 45;
   localparam int SETTLE_CYCLES   = 80;
   localparam logic [BYTE_W-1:0] CHAR_DASH = 8'h2d;

   typedef enum logic [2:0] {
      ST_DELIM,
      ST_DELIM_LF,
      ST_HEADER,
      ST_BODY,
      ST_TRAIL_CR,
      ST_TRAIL_LF,
      ST_DONE
   } scan_state_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              stream_end;
   } stream_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      kind_type          kind;
      logic [IDX_W-1:0]  part_index;
      logic              last;
   } deframe_result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [KIND_W-1:0]     rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [MAXP_W-1:0]     csr_data   = '0;

   multipart_body_deframer_top #(
      .DELIM_MAX (DELIM_MAX),
      .PART_LIMIT(PART_LIMIT)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // deframer prediction state
   logic [MAXP_W-1:0]  part_limit_reg;
   scan_state_type     scan_state;
   logic [BYTE_W-1:0]  delim_mem [0:DELIM_MAX-1];
   int                 delim_len;
   int                 match_cnt;
   logic [MAXP_W-1:0]  part_cnt;
   logic               line_empty;
   logic               cr_pending;
   deframe_result_type held_result;
   bit                 have_held;
   deframe_result_type expected_q [$];

   stream_item_type   pending_items [$];
   int                items_queued   = 0;
   int                items_accepted = 0;
   int                cut_left       = -1;
   int                mismatch_count = 0;

   function automatic void queue_result(logic [BYTE_W-1:0] b, kind_type k);
      if (have_held)
         expected_q.push_back(held_result);
      held_result.out_byte   = b;
      held_result.kind       = k;
      held_result.part_index = (part_cnt > MAXP_W'(IDX_SAT)) ? IDX_SAT : part_cnt[IDX_W-1:0];
      held_result.last       = 1'b0;
      have_held              = 1'b1;
   endfunction

   function automatic void clear_scan();
      int i;
      scan_state = ST_DELIM;
      for (i = 0; i < DELIM_MAX; i++)
         delim_mem[i] = '0;
      delim_mem[0] = CHAR_CR;
      delim_mem[1] = CHAR_LF;
      delim_len    = 2;
      match_cnt    = 0;
      part_cnt     = '0;
      line_empty   = 1'b1;
      cr_pending   = 1'b0;
   endfunction

   function automatic logic [MAXP_W-1:0] active_limit();
      return (int'(part_limit_reg) < PART_LIMIT) ? part_limit_reg : MAXP_W'(PART_LIMIT);
   endfunction

   function automatic void end_message();
      queue_result('0, KIND_MEND);
      scan_state = ST_DONE;
   endfunction

   function automatic void open_part();
      if (part_cnt >= active_limit()) begin
         end_message();
      end else begin
         scan_state = ST_HEADER;
         line_empty = 1'b1;
         cr_pending = 1'b0;
      end
   endfunction

   function automatic void header_step(logic [BYTE_W-1:0] b);
      if (cr_pending) begin
         cr_pending = 1'b0;
         if (b == CHAR_LF) begin
            if (line_empty) begin
               scan_state = ST_BODY;
               match_cnt  = 0;
            end else begin
               queue_result(CHAR_CR, KIND_HEAD);
               queue_result(CHAR_LF, KIND_HEAD);
               line_empty = 1'b1;
            end
            return;
         end
         queue_result(CHAR_CR, KIND_HEAD);
         line_empty = 1'b0;
      end
      if (b == CHAR_CR) begin
         cr_pending = 1'b1;
      end else if (b == CHAR_LF) begin
         if (line_empty) begin
            scan_state = ST_BODY;
            match_cnt  = 0;
         end else begin
            queue_result(CHAR_LF, KIND_HEAD);
            line_empty = 1'b1;
         end
      end else begin
         queue_result(b, KIND_HEAD);
         line_empty = 1'b0;
      end
   endfunction

   function automatic void body_step(logic [BYTE_W-1:0] b);
      int i;
      if (match_cnt < DELIM_MAX && b == delim_mem[match_cnt]) begin
         match_cnt++;
      end else begin
         // replay the partly matched delimiter
         for (i = 0; i < match_cnt && i < DELIM_MAX; i++)
            queue_result(delim_mem[i], KIND_BODY);
         match_cnt = 0;
         if (b == delim_mem[0])
            match_cnt = 1;
         else
            queue_result(b, KIND_BODY);
      end
      if (match_cnt != 0 && match_cnt >= delim_len) begin
         queue_result('0, KIND_PEND);
         part_cnt++;
         match_cnt  = 0;
         scan_state = ST_TRAIL_CR;
      end
   endfunction

   function automatic void predict_transfer(logic [BYTE_W-1:0] b, logic stream_end);
      have_held = 1'b0;
      if (stream_end) begin
         if (scan_state != ST_DONE) begin
            if (scan_state == ST_HEADER || scan_state == ST_BODY ||
                ((scan_state == ST_DELIM || scan_state == ST_DELIM_LF) &&
                 part_cnt < active_limit())) begin
               queue_result('0, KIND_PEND);
               part_cnt++;
            end
            end_message();
         end
         clear_scan();
      end else begin
         case (scan_state)
            ST_DELIM: begin
               if (b == CHAR_CR) begin
                  scan_state = ST_DELIM_LF;
               end else if (delim_len >= DELIM_MAX) begin
                  open_part();
               end else begin
                  delim_mem[delim_len] = b;
                  delim_len++;
               end
            end
            ST_DELIM_LF: open_part();
            ST_HEADER:   header_step(b);
            ST_BODY:     body_step(b);
            ST_TRAIL_CR: begin
               if (b == CHAR_CR)
                  scan_state = ST_TRAIL_LF;
               else
                  end_message();
            end
            ST_TRAIL_LF: begin
               if (b == CHAR_LF)
                  open_part();
               else
                  end_message();
            end
            default: ;
         endcase
      end
      if (have_held) begin
         held_result.last = 1'b1;
         expected_q.push_back(held_result);
      end
   endfunction

   // stimulus
   function automatic logic [BYTE_W-1:0] printable();
      return BYTE_W'($urandom_range(33, 126));
   endfunction

   task automatic push_byte(input logic [BYTE_W-1:0] b);
      if (cut_left != 0) begin
         pending_items.push_back({b, 1'b0});
         items_queued++;
         if (cut_left > 0)
            cut_left--;
      end
   endtask

   task automatic push_end();
      pending_items.push_back({BYTE_W'($urandom_range(0, 255)), 1'b1});
      items_queued++;
      cut_left = -1;
   endtask

   task automatic push_line_end();
      push_byte(CHAR_CR);
      push_byte(CHAR_LF);
   endtask

   task automatic directed_stream();
      push_byte(CHAR_DASH);
      push_line_end();
      push_byte("h");
      push_byte(CHAR_CR);
      push_byte("q");
      push_byte(CHAR_LF);
      push_byte(8'h00);
      push_byte(8'hff);
      push_line_end();
      push_line_end();
      push_byte(8'hff);
      push_byte(CHAR_CR);
      push_byte("z");
      push_line_end();
      push_byte(CHAR_DASH);
      push_line_end();
      push_byte(CHAR_LF);
      push_line_end();
      push_byte("q");
      push_end();
      push_end();
   endtask

   task automatic gen_message();
      logic [BYTE_W-1:0] bnd [0:79];
      int dlen, sdl, nparts, n, k, i, p;
      if ($urandom_range(0, 9) == 0) begin
         n = $urandom_range(1, 30);
         repeat (n) begin
            if ($urandom_range(0, 3) == 0)
               push_byte($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
            else
               push_byte(BYTE_W'($urandom_range(0, 255)));
         end
         push_end();
         return;
      end
      cut_left = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 50) : -1;
      dlen = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 6);
      sdl  = (dlen > DELIM_MAX - 2) ? DELIM_MAX - 2 : dlen;
      for (i = 0; i < dlen; i++) begin
         bnd[i] = printable();
         push_byte(bnd[i]);
      end
      push_line_end();
      nparts = $urandom_range(1, 2);
      for (p = 0; p < nparts; p++) begin
         repeat ($urandom_range(0, 2)) begin
            n = $urandom_range(1, 6);
            repeat (n) begin
               if ($urandom_range(0, 9) == 0)
                  push_byte(CHAR_CR);
               push_byte(printable());
            end
            if ($urandom_range(0, 3) != 0)
               push_byte(CHAR_CR);
            push_byte(CHAR_LF);
         end
         if ($urandom_range(0, 4) != 0)
            push_byte(CHAR_CR);
         push_byte(CHAR_LF);
         n = $urandom_range(0, 10);
         repeat (n) begin
            if ($urandom_range(0, 4) == 0) begin
               push_line_end();
               k = $urandom_range(0, sdl - 1);
               for (i = 0; i < k; i++)
                  push_byte(bnd[i]);
            end
            push_byte(BYTE_W'($urandom_range(0, 255)));
         end
         push_line_end();
         for (i = 0; i < sdl; i++)
            push_byte(bnd[i]);
         if (p < nparts - 1)
            push_line_end();
      end
      case ($urandom_range(0, 3))
         0: begin
            push_byte(CHAR_DASH);
            push_byte(CHAR_DASH);
            push_line_end();
            repeat ($urandom_range(0, 4))
               push_byte(BYTE_W'($urandom_range(0, 255)));
         end
         1: push_line_end();
         2: push_byte(BYTE_W'($urandom_range(0, 255)));
         default: ;
      endcase
      push_end();
   endtask

   task automatic wait_idle();
      while (items_accepted != items_queued || expected_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [MAXP_W-1:0] v);
      @(posedge clock);
      csr_data  <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid      <= 1'b0;
      part_limit_reg  = v;
   endtask

   // sender
   stream_item_type next_item;
   int              burst_left = 1;
   int              gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_transfer(req_tdata, req_tuser);
            items_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               next_item   = pending_items.pop_front();
               req_tdata  <= next_item.data_byte;
               req_tuser  <= next_item.stream_end;
               req_tvalid <= 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                            : $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver and result check
   deframe_result_type want;
   int                 stall_mode = 0;
   int                 mode_left  = 0;
   int                 stall_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result: tdata=%h tuser=%0d tlast=%0b",
                           rsp_tdata, rsp_tuser, rsp_tlast);
            end else begin
               want = expected_q.pop_front();
               if ({rsp_tdata, rsp_tuser, rsp_tlast} !==
                   {6'b0, want.part_index, want.out_byte, want.kind, want.last}) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"mismatch: expected byte=%h kind=%0d index=%0d last=%0b,",
                               " got tdata=%h kind=%0d last=%0b"},
                              want.out_byte, want.kind, want.part_index, want.last,
                              rsp_tdata, rsp_tuser, rsp_tlast);
               end
            end
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(50, 300);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 2) != 0);
            2: begin
               if (stall_left > 0) begin
                  stall_left--;
                  rsp_tready <= 1'b0;
               end else begin
                  rsp_tready <= 1'b1;
                  if ($urandom_range(0, 5) == 0)
                     stall_left = $urandom_range(1, 5);
               end
            end
            default: rsp_tready <= (mode_left % 3) != 0;
         endcase
      end
   end

   initial begin
      int                ph;
      int                target;
      logic [MAXP_W-1:0] limit_plan [0:7];
      limit_plan = '{MAX_PARTS_RESET, 11'd1, 11'd2, 11'd0, 11'd3,
                     MAXP_W'($urandom_range(4, 1023)), 11'd2047, MAX_PARTS_RESET};
      part_limit_reg = MAX_PARTS_RESET;
      clear_scan();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      for (ph = 0; ph < 8; ph++) begin
         write_limit(limit_plan[ph]);
         if (ph == 0)
            directed_stream();
         target = (ph + 1) * ITEMS_PER_PHASE;
         do
            gen_message();
         while (items_queued < target);
         wait_idle();
      end
      if (mismatch_count == 0 && expected_q.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #12000000;
      $display("status: fail");
      $finish;
   end

endmodule
